/* hw/rtl/tdf_pkg.sv */
// ----------------------------------------------------------------------------
// tdf_pkg - trial division factorizer shared definitions
// Widths, the divisor limit, sequencer states and divider handshake structs.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int NUM_W = 32;                 // width of the number and factors
    localparam int DIV_W = 16;                 // width of a trial divisor
    localparam int CNT_W = $clog2(NUM_W);      // divider step counter

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [DIV_W-1:0] t_dvs;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_dvs DIVISOR_LIMIT = t_dvs'(65535);
    localparam t_dvs DIVISOR_FIRST = t_dvs'(2);
    localparam t_num NUM_ONE       = t_num'(1);
    localparam t_num NUM_TWO       = t_num'(2);
    localparam t_cnt CNT_LAST      = t_cnt'(NUM_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_EMIT_DIV,
        ST_EMIT_REM,
        ST_EMIT_BAD
    } t_state;

    // divider launch
    typedef struct packed {
        logic start;
        t_num dividend;
        t_dvs divisor;
    } t_div_req;

    // divider result, valid while done is high
    typedef struct packed {
        logic done;
        t_num quotient;
        t_dvs remainder;
    } t_div_rsp;

endpackage

/* hw/rtl/tdf_div.sv */
// ----------------------------------------------------------------------------
// tdf_div - radix-2 restoring divider
// One quotient bit per cycle; done pulses as the last step's result is stored.
// ----------------------------------------------------------------------------
module tdf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdf_pkg::t_div_req i_req,
    output tdf_pkg::t_div_rsp o_rsp
);

    logic          r_busy;
    logic          r_done;
    tdf_pkg::t_cnt r_cnt;
    tdf_pkg::t_num r_q;    // dividend bits out at the top, quotient bits in at the bottom
    tdf_pkg::t_dvs r_r;    // partial remainder
    tdf_pkg::t_dvs r_d;

    logic [tdf_pkg::DIV_W:0]   trial;
    logic [tdf_pkg::DIV_W+1:0] diff;
    logic                      fits;

    assign trial = {r_r, r_q[tdf_pkg::NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_d};
    assign fits  = ~diff[tdf_pkg::DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tdf_pkg::CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[tdf_pkg::NUM_W-2:0], fits};
            r_r <= fits ? diff[tdf_pkg::DIV_W-1:0] : trial[tdf_pkg::DIV_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_r;

endmodule

/* hw/rtl/trial_division_factorizer.sv */
// ----------------------------------------------------------------------------
// trial_division_factorizer - distinct prime factors of a 32-bit number
// Trial divisors 2..65535 on one shared divider; one beat per distinct factor.
// ----------------------------------------------------------------------------
// Each trial division loads the divider, runs its 32 radix-2 steps and
//   decides; each emitted beat takes an emit state, which waits while the
//   output is full. Worst case (a large prime) is about 65534 trials.
// One number is taken at a time; the search ends early once the remainder
//   hits 1 or is proven prime (quotient below the divisor).
// Reset: synchronous active-low i_rst_n returns to idle, output beat dropped.
// ----------------------------------------------------------------------------
module trial_division_factorizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] number
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] factor
    output logic        o_m_tlast,   // final factor of this number
    output logic [0:0]  o_m_tuser    // [0] invalid (number below 2)
);

    // sequencer state
    tdf_pkg::t_state r_state, n_state;
    tdf_pkg::t_num   r_rem,   n_rem;     // remainder still to factor
    tdf_pkg::t_dvs   r_div,   n_div;     // current trial divisor
    logic            r_found, n_found;   // current divisor divided at least once
    logic            r_prime, n_prime;   // remainder proven prime

    // output register
    logic            r_out_valid, n_out_valid;
    tdf_pkg::t_num   r_factor,    n_factor;
    logic            r_last,      n_last;
    logic            r_invalid,   n_invalid;

    tdf_pkg::t_div_req div_req;
    tdf_pkg::t_div_rsp div_rsp;

    logic out_free;
    logic in_beat;
    logic at_limit;
    logic q_below;

    tdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || i_m_tready;
    assign in_beat  = i_s_tvalid && o_s_tready;
    assign at_limit = (r_div == tdf_pkg::DIVISOR_LIMIT);
    // rem = q*div + r with q < div means rem < div^2: no factor left below sqrt
    assign q_below  = (div_rsp.quotient < {{(tdf_pkg::NUM_W-tdf_pkg::DIV_W){1'b0}}, r_div});

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_div       = r_div;
        n_found     = r_found;
        n_prime     = r_prime;
        n_out_valid = r_out_valid && !i_m_tready;
        n_factor    = r_factor;
        n_last      = r_last;
        n_invalid   = r_invalid;
        o_s_tready  = 1'b0;

        div_req.start    = 1'b0;
        div_req.dividend = r_rem;
        div_req.divisor  = r_div + 1'b1;

        unique case (r_state)
            tdf_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (in_beat) begin
                    if (i_s_tdata < tdf_pkg::NUM_TWO) begin
                        n_state = tdf_pkg::ST_EMIT_BAD;
                    end else begin
                        n_state          = tdf_pkg::ST_TRIAL;
                        n_rem            = i_s_tdata;
                        n_div            = tdf_pkg::DIVISOR_FIRST;
                        n_found          = 1'b0;
                        n_prime          = 1'b0;
                        div_req.start    = 1'b1;
                        div_req.dividend = i_s_tdata;
                        div_req.divisor  = tdf_pkg::DIVISOR_FIRST;
                    end
                end
            end

            tdf_pkg::ST_TRIAL: begin
                if (div_rsp.done) begin
                    if (div_rsp.remainder == '0) begin
                        // divides: take it out and try the same divisor again
                        n_rem            = div_rsp.quotient;
                        n_found          = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = r_div;
                    end else if (r_found) begin
                        n_prime = q_below;
                        n_state = tdf_pkg::ST_EMIT_DIV;
                    end else if (q_below || at_limit) begin
                        n_state = tdf_pkg::ST_EMIT_REM;
                    end else begin
                        n_div         = r_div + 1'b1;
                        div_req.start = 1'b1;
                    end
                end
            end

            tdf_pkg::ST_EMIT_DIV: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_factor    = {{(tdf_pkg::NUM_W-tdf_pkg::DIV_W){1'b0}}, r_div};
                    n_last      = (r_rem == tdf_pkg::NUM_ONE);
                    n_invalid   = 1'b0;
                    n_found     = 1'b0;
                    priority if (r_rem == tdf_pkg::NUM_ONE) begin
                        n_state = tdf_pkg::ST_IDLE;
                    end else if (r_prime || at_limit) begin
                        n_state = tdf_pkg::ST_EMIT_REM;
                    end else begin
                        n_state       = tdf_pkg::ST_TRIAL;
                        n_div         = r_div + 1'b1;
                        div_req.start = 1'b1;
                    end
                end
            end

            tdf_pkg::ST_EMIT_REM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_factor    = r_rem;
                    n_last      = 1'b1;
                    n_invalid   = 1'b0;
                    n_state     = tdf_pkg::ST_IDLE;
                end
            end

            tdf_pkg::ST_EMIT_BAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_factor    = '0;
                    n_last      = 1'b1;
                    n_invalid   = 1'b1;
                    n_state     = tdf_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tdf_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_prime     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_prime     <= n_prime;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_factor  <= n_factor;
        r_last    <= n_last;
        r_invalid <= n_invalid;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_factor;
    assign o_m_tlast    = r_last;
    assign o_m_tuser[0] = r_invalid;

endmodule

/* tb/factor_checker.sv */
// ----------------------------------------------------------------------------
// factor_checker - scoreboard for the trial division factorizer
// Watches both streams, works out the distinct prime factors of every number
// taken in, and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module factor_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] number
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] factor
    input  logic        i_m_tlast,
    input  logic [0:0]  i_m_tuser,   // [0] invalid
    output int          o_mismatches,
    output int          o_beats_due
);

    localparam int MAX_FACTORS = 9;

    typedef struct {
        tdf_pkg::t_num factor;
        logic          last;
        logic          invalid;
    } t_factor_beat;

    t_factor_beat factor_beats_due[$];
    int           mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what);
        $display("[%0t] factor mismatch: %s", $time, what);
        mismatches++;
    endtask

    // distinct prime factors, ascending, by trial division up to the limit
    function automatic void predict_factors(input tdf_pkg::t_num number);
        t_factor_beat  found[$];
        t_factor_beat  beat;
        tdf_pkg::t_num rem;
        logic [31:0]   dvs;
        rem = number;
        beat.last    = 1'b0;
        beat.invalid = 1'b0;
        if (rem < tdf_pkg::NUM_TWO) begin
            beat.factor  = '0;
            beat.invalid = 1'b1;
            found.push_back(beat);
        end else begin
            for (dvs = 32'(tdf_pkg::DIVISOR_FIRST);
                 dvs <= 32'(tdf_pkg::DIVISOR_LIMIT) && rem > tdf_pkg::NUM_ONE;
                 dvs++) begin
                if (rem % dvs == 0) begin
                    while (rem % dvs == 0)
                        rem = rem / dvs;
                    if (found.size() < MAX_FACTORS) begin
                        beat.factor = dvs;
                        found.push_back(beat);
                    end
                end
            end
            // leftover above one is the top factor
            if (rem > tdf_pkg::NUM_ONE && found.size() < MAX_FACTORS) begin
                beat.factor = rem;
                found.push_back(beat);
            end
        end
        found[found.size()-1].last = 1'b1;
        foreach (found[i])
            factor_beats_due.push_back(found[i]);
    endfunction

    always @(posedge i_clk) begin
        t_factor_beat want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                predict_factors(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (factor_beats_due.size() == 0) begin
                    report_mismatch($sformatf("beat with nothing due, factor %0d",
                                              i_m_tdata));
                end else begin
                    want = factor_beats_due.pop_front();
                    if (i_m_tdata !== want.factor)
                        report_mismatch($sformatf("factor %0d, want %0d",
                                                  i_m_tdata, want.factor));
                    if (i_m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, want %b (factor %0d)",
                                                  i_m_tlast, want.last, want.factor));
                    if (i_m_tuser[0] !== want.invalid)
                        report_mismatch($sformatf("invalid %b, want %b (factor %0d)",
                                                  i_m_tuser[0], want.invalid,
                                                  want.factor));
                end
            end
        end
        // anything still due is a failure too; the top reads this
        o_beats_due <= factor_beats_due.size();
    end

endmodule

/* tb/tb_trial_division_factorizer.sv */
// ----------------------------------------------------------------------------
// tb_trial_division_factorizer - stream test of the trial division factorizer
// Directed corner numbers, then random smooth and semi-smooth numbers kept
// cheap to factor, with random gaps and stalls on both streams. A separate
// checker predicts the factor beats and counts mismatches.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer;

    // cycles with no beat on either side before the run is called hung
    localparam int IDLE_LIMIT   = 200_000;
    localparam int RANDOM_ITEMS = 80;
    localparam int DRAIN_CYCLES = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] number
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] factor
    logic        m_tlast;
    logic [0:0]  m_tuser;     // [0] invalid

    int mismatches;
    int beats_due;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;   // no new gaps or stalls while set

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    trial_division_factorizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    factor_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_mismatches (mismatches),
        .o_beats_due  (beats_due)
    );

    // mostly short idles, now and then a long one
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm)      return 0;
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        if (roll < 98) return $urandom_range(5, 20);
        return $urandom_range(50, 200);
    endfunction

    // product of up to n random factors in 2..251, never past 32 bits;
    // keeps the search short since no prime factor exceeds 251
    function automatic longint unsigned smooth_number(input int n);
        longint unsigned prod;
        longint unsigned f;
        prod = 1;
        repeat (n) begin
            f = $urandom_range(2, 251);
            if (prod * f <= 64'hFFFF_FFFF)
                prod = prod * f;
        end
        return prod;
    endfunction

    // random number whose search stays cheap
    function automatic logic [31:0] pick_number();
        int              roll;
        longint unsigned prod;
        longint unsigned cap;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return 32'($urandom_range(0, 1));              // below two
        if (roll < 14)
            return 32'($urandom_range(2, 65535));          // 16-bit range
        if (roll < 50)
            return 32'(smooth_number($urandom_range(1, 14)));
        // smooth part times a cofactor that often leaves a large prime
        prod = smooth_number($urandom_range(0, 3));
        cap  = 64'hFFFF_FFFF / prod;
        if (cap > (1 << 18))
            cap = 1 << 18;
        return 32'(prod * $urandom_range(2, int'(cap)));
    endfunction

    // one beat on the input stream; called right after a rising edge
    task automatic send_number(input logic [31:0] number);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // hold off until every factor beat due has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (beats_due != 0);
    endtask

    // receiver side backpressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left <= pick_idle();
        end
    end

    // hang detector: no beat on either stream for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] corner_numbers[$];
        corner_numbers = '{
            32'd0, 32'd1,                 // below two
            32'd2, 32'd3, 32'd4,          // smallest valid, prime power
            32'h8000_0000,                // single factor, top bit
            32'hFFFF_FFFF,                // all ones: 3*5*17*257*65537
            32'd4294836225,               // limit squared: every prime factor squared
            32'd65537,                    // prime just past 16 bits
            32'd131042,                   // 2 * largest 16-bit prime
            32'd223092870,                // nine distinct primes
            32'h5555_5555, 32'hAAAA_AAAA,
            32'h3333_3333, 32'hCCCC_CCCC,
            32'h0F0F_0F0F, 32'hF0F0_F0F0,
            32'd912673,                   // 97 cubed
            32'd1024, 32'd30, 32'd9699690
        };

        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_numbers[i])
            send_number(corner_numbers[i]);

        // sender waits for the block to empty before the random part
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 30 && n < 45);
            if (n == 60)
                drain_results();
            send_number(pick_number());
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && beats_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_div.sv
hw/rtl/trial_division_factorizer.sv
tb/factor_checker.sv
tb/tb_trial_division_factorizer.sv
